### rtl/rhvf_pkg.sv
// ----------------------------------------------------------------------------
// rhvf_pkg
// Shared types and constants of the rangefinder height and velocity filter.
// ----------------------------------------------------------------------------
package rhvf_pkg;

	localparam int FRACTION_BITS = 8;
	localparam int HEIGHT_W      = 24;
	localparam int VEL_W         = 21;
	localparam int DIV_STEPS     = 34;
	localparam logic [15:0] BAD_STRENGTH = 16'hFFFF;

	// Configuration register indexes.
	localparam logic [2:0] REG_MIN_DIST  = 3'd0;
	localparam logic [2:0] REG_MAX_DIST  = 3'd1;
	localparam logic [2:0] REG_MIN_STR   = 3'd2;
	localparam logic [2:0] REG_TIMEOUT   = 3'd3;
	localparam logic [2:0] REG_H_GAIN    = 3'd4;
	localparam logic [2:0] REG_V_GAIN    = 3'd5;
	localparam logic [2:0] REG_VEL_LIMIT = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_HEIGHT,
		ST_DIVIDE,
		ST_VELOCITY,
		ST_FINISH,
		ST_OUTPUT
	} rhvf_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // Capture the input word.
		logic check;      // Evaluate acceptance and update the counters.
		logic height;     // Seed or average the height.
		logic div_start;  // Set up the rate division.
		logic div_step;   // Dividend load, then one restoring division step.
		logic velocity;   // Clamp the rate and average it into the velocity.
		logic finish;     // Apply the timeout and form the result word.
	} rhvf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic accept;     // The frame passed the checks.
		logic seed;       // No accepted time yet: the frame seeds the height.
		logic rate_ok;    // The time gap allows a velocity update.
		logic div_done;   // Last division step taken.
	} rhvf_stat_t;

endpackage

### rtl/rhvf_ctrl.sv
// ----------------------------------------------------------------------------
// rhvf_ctrl
// Sequencer for one tick: check, height update, rate division, velocity update, finish, output.
// ----------------------------------------------------------------------------
module rhvf_ctrl import rhvf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  rhvf_stat_t stat,
	output rhvf_cmd_t  cmd
);

	rhvf_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_nxt = ST_CHECK;
			ST_CHECK:    state_nxt = stat.accept ? ST_HEIGHT : ST_FINISH;
			ST_HEIGHT:   state_nxt = (!stat.seed && stat.rate_ok) ? ST_DIVIDE : ST_FINISH;
			ST_DIVIDE:   if (stat.div_done) state_nxt = ST_VELOCITY;
			ST_VELOCITY: state_nxt = ST_FINISH;
			ST_FINISH:   state_nxt = ST_OUTPUT;
			ST_OUTPUT:   if (out_ready) state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CHECK:    cmd.check = 1'b1;
			ST_HEIGHT: begin
				cmd.height    = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIVIDE:   cmd.div_step = 1'b1;
			ST_VELOCITY: cmd.velocity = 1'b1;
			ST_FINISH:   cmd.finish = 1'b1;
			ST_OUTPUT:   out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

### rtl/rhvf_datapath.sv
// ----------------------------------------------------------------------------
// rhvf_datapath
// Filter state, acceptance checks, averaging steps and a bit-serial divider.
// ----------------------------------------------------------------------------
module rhvf_datapath import rhvf_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rhvf_cmd_t                  cmd,
	output rhvf_stat_t                 stat,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [19:0]                cfg_data,
	input  logic                       new_frame,
	input  logic [15:0]                range_cm,
	input  logic [15:0]                signal_strength,
	input  logic [31:0]                frame_time_ms,
	input  logic [31:0]                now_ms,
	output logic                       valid_res,
	output logic [HEIGHT_W-1:0]        height,
	output logic signed [VEL_W-1:0]    velocity,
	output logic [31:0]                last_frame_time_ms,
	output logic [31:0]                age_ms,
	output logic [31:0]                rejected_count,
	output logic [31:0]                weak_count,
	output logic [15:0]                last_range_cm,
	output logic [15:0]                last_strength
);

	// Configuration.
	logic [15:0] min_dist_q, max_dist_q, min_str_q, timeout_q;
	logic [8:0]  h_gain_q, v_gain_q;
	logic [19:0] vel_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q  <= 16'd2;
			max_dist_q  <= 16'd1200;
			min_str_q   <= 16'd80;
			timeout_q   <= 16'd100;
			h_gain_q    <= 9'd90;
			v_gain_q    <= 9'd51;
			vel_limit_q <= 20'd128000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DIST:  min_dist_q  <= cfg_data[15:0];
				REG_MAX_DIST:  max_dist_q  <= cfg_data[15:0];
				REG_MIN_STR:   min_str_q   <= cfg_data[15:0];
				REG_TIMEOUT:   timeout_q   <= cfg_data[15:0];
				REG_H_GAIN:    h_gain_q    <= cfg_data[8:0];
				REG_V_GAIN:    v_gain_q    <= cfg_data[8:0];
				REG_VEL_LIMIT: vel_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured input word.
	logic        frame_q;
	logic [15:0] dist_q, str_q;
	logic [31:0] ftime_q, now_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame_q <= new_frame;
			dist_q  <= range_cm;
			str_q   <= signal_strength;
			ftime_q <= frame_time_ms;
			now_q   <= now_ms;
		end
	end

	// Filter state.
	logic [HEIGHT_W-1:0]     height_q, prior_q;
	logic signed [VEL_W-1:0] vel_q;
	logic [31:0]             acc_time_q, seen_time_q, rej_q, weak_q;
	logic                    valid_q, seed_q;
	logic [15:0]             seen_dist_q, seen_str_q;

	logic dist_ok, str_ok;
	assign dist_ok = (dist_q >= min_dist_q) && (dist_q <= max_dist_q);
	assign str_ok  = (str_q >= min_str_q) && (str_q != BAD_STRENGTH);

	logic [31:0] dt;
	assign dt = ftime_q - acc_time_q;

	// Seed value, saturated to the height width.
	logic [16+FRACTION_BITS-1:0] raw_full;
	logic [HEIGHT_W-1:0]         raw_h;
	assign raw_full = {dist_q, {FRACTION_BITS{1'b0}}};
	always_comb begin
		if (16 + FRACTION_BITS > HEIGHT_W && (raw_full >> HEIGHT_W) != '0)
			raw_h = '1;
		else
			raw_h = HEIGHT_W'(raw_full);
	end

	// Height average: x + floor((g*(t-x)+128)/256); arithmetic shift is floor.
	logic [8:0]         h_gain_c, v_gain_c;
	logic signed [25:0] h_diff;
	logic signed [35:0] h_prod;
	logic signed [27:0] h_step;
	logic [HEIGHT_W-1:0] h_new;
	assign h_gain_c = (h_gain_q > 9'd256) ? 9'd256 : h_gain_q;
	assign v_gain_c = (v_gain_q > 9'd256) ? 9'd256 : v_gain_q;
	assign h_diff = $signed({2'b00, raw_h}) - $signed({2'b00, height_q});
	assign h_prod = h_diff * $signed({1'b0, h_gain_c}) + 36'sd128;
	assign h_step = 28'(h_prod >>> 8);
	assign h_new  = HEIGHT_W'($signed({4'b0000, height_q}) + h_step);

	// Divider: |(height - prior) * 1000| / dt, one quotient bit per step.
	// The first step cycle loads the dividend from the updated height.
	logic [HEIGHT_W-1:0] prior_prev_q;
	logic [33:0]         dividend_q, quot_q;
	logic [31:0]         div_rem_q, dt_q;
	logic                neg_q, div_load_q;
	logic [5:0]          div_cnt_q;
	logic signed [24:0]  rate_delta;
	logic [24:0]         rd_mag;
	logic [33:0]         prod_mag;
	logic [32:0]         rem_shift;

	assign rate_delta = $signed({1'b0, height_q}) - $signed({1'b0, prior_prev_q});
	assign rd_mag     = rate_delta[24] ? 25'(-rate_delta) : 25'(rate_delta);
	assign prod_mag   = 34'(rd_mag) * 34'd1000;
	assign rem_shift  = {div_rem_q, dividend_q[33]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dt_q         <= dt;
			prior_prev_q <= prior_q;
			div_load_q   <= 1'b1;
			div_cnt_q    <= '0;
		end else if (cmd.div_step) begin
			if (div_load_q) begin
				dividend_q <= prod_mag;
				neg_q      <= rate_delta[24];
				quot_q     <= '0;
				div_rem_q  <= '0;
				div_load_q <= 1'b0;
			end else begin
				dividend_q <= {dividend_q[32:0], 1'b0};
				div_cnt_q  <= div_cnt_q + 6'd1;
				if (rem_shift >= {1'b0, dt_q}) begin
					div_rem_q <= 32'(rem_shift - {1'b0, dt_q});
					quot_q    <= {quot_q[32:0], 1'b1};
				end else begin
					div_rem_q <= rem_shift[31:0];
					quot_q    <= {quot_q[32:0], 1'b0};
				end
			end
		end
	end

	assign stat.div_done = cmd.div_step && !div_load_q &&
		(div_cnt_q == 6'(DIV_STEPS - 1));

	// Rate clamp and velocity average.
	logic signed [32:0] rate_s, lim_s, quot_s;
	assign lim_s  = $signed({13'd0, vel_limit_q});
	assign quot_s = $signed({13'd0, quot_q[19:0]});
	always_comb begin
		if (quot_q > {14'd0, vel_limit_q})
			rate_s = neg_q ? -lim_s : lim_s;
		else
			rate_s = neg_q ? -quot_s : quot_s;
	end
	logic signed [33:0] v_diff;
	logic signed [43:0] v_prod;
	logic signed [VEL_W-1:0] v_new;
	assign v_diff = 34'(rate_s) - 34'(vel_q);
	assign v_prod = 44'(v_diff) * $signed({1'b0, v_gain_c}) + 44'sd128;
	assign v_new  = VEL_W'(vel_q + 21'(v_prod >>> 8));

	logic [31:0] age_c;
	assign age_c = now_q - acc_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q    <= '0;
			prior_q     <= '0;
			vel_q       <= '0;
			acc_time_q  <= '0;
			seen_time_q <= '0;
			valid_q     <= 1'b0;
			rej_q       <= '0;
			weak_q      <= '0;
			seen_dist_q <= '0;
			seen_str_q  <= '0;
			seed_q      <= 1'b0;
		end else begin
			if (cmd.check) begin
				seed_q <= (acc_time_q == '0);
				if (frame_q) begin
					seen_dist_q <= dist_q;
					seen_str_q  <= str_q;
					seen_time_q <= ftime_q;
					if (!(dist_ok && str_ok)) begin
						rej_q <= rej_q + 32'd1;
						if (!str_ok) weak_q <= weak_q + 32'd1;
					end
				end
			end
			if (cmd.height) begin
				if (seed_q) begin
					height_q <= raw_h;
					prior_q  <= raw_h;
					vel_q    <= '0;
				end else begin
					height_q <= h_new;
					prior_q  <= h_new;
				end
				acc_time_q <= ftime_q;
				valid_q    <= 1'b1;
			end
			if (cmd.velocity) vel_q <= v_new;
			if (cmd.finish) begin
				if (acc_time_q == '0 || age_c > {16'd0, timeout_q}) begin
					valid_q <= 1'b0;
					vel_q   <= '0;
				end
			end
		end
	end

	assign stat.accept  = frame_q && dist_ok && str_ok;
	assign stat.seed    = seed_q;
	assign stat.rate_ok = (dt >= 32'd2) && (dt <= {16'd0, timeout_q});

	assign valid_res          = valid_q;
	assign height             = height_q;
	assign velocity           = vel_q;
	assign last_frame_time_ms = seen_time_q;
	assign age_ms             = (seen_time_q != '0) ? (now_q - seen_time_q) : '1;
	assign rejected_count     = rej_q;
	assign weak_count         = weak_q;
	assign last_range_cm      = seen_dist_q;
	assign last_strength      = seen_str_q;

endmodule

### rtl/range_height_velocity_filter_core.sv
// ----------------------------------------------------------------------------
// range_height_velocity_filter_core
// Rangefinder height and vertical velocity filter, top level.
// ----------------------------------------------------------------------------
// One word per service tick in, one result word out. A tick whose frame is
// absent or rejected goes from the check straight to the finish step; an
// accepted frame also updates the height, and one that updates the velocity
// also runs the bit-serial rate divider: a dividend load, then DIV_STEPS
// restoring steps of one quotient bit each. A result is held until it is
// taken, and a new word is taken only once the previous result has been
// delivered.
module range_height_velocity_filter_core import rhvf_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [2:0]              cfg_index,
	input  logic [19:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    new_frame,
	input  logic [15:0]             range_cm,
	input  logic [15:0]             signal_strength,
	input  logic [31:0]             frame_time_ms,
	input  logic [31:0]             now_ms,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    valid_res,
	output logic [HEIGHT_W-1:0]     height,
	output logic signed [VEL_W-1:0] velocity,
	output logic [31:0]             last_frame_time_ms,
	output logic [31:0]             age_ms,
	output logic [31:0]             rejected_count,
	output logic [31:0]             weak_count,
	output logic [15:0]             last_range_cm,
	output logic [15:0]             last_strength
);

	rhvf_cmd_t  cmd;
	rhvf_stat_t stat;

	rhvf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd)
	);

	rhvf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.new_frame(new_frame), .range_cm(range_cm),
		.signal_strength(signal_strength), .frame_time_ms(frame_time_ms),
		.now_ms(now_ms), .valid_res(valid_res), .height(height),
		.velocity(velocity), .last_frame_time_ms(last_frame_time_ms),
		.age_ms(age_ms), .rejected_count(rejected_count),
		.weak_count(weak_count), .last_range_cm(last_range_cm),
		.last_strength(last_strength)
	);

endmodule

### rtl/rhvf_checker.sv
// ----------------------------------------------------------------------------
// rhvf_checker
// Port-level checks of the filter top level.
// ----------------------------------------------------------------------------
module rhvf_checker import rhvf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic                    valid_res,
	input logic signed [VEL_W-1:0] velocity,
	input logic [31:0]             rejected_count
);

	// A result word stays offered, with its velocity stable, while it waits.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(velocity))
		else $error("result word changed while stalled");

	// Only one word is in flight.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result waits");

	// An invalid result always shows zero velocity.
	a_invalid_vel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> velocity == '0)
		else $error("velocity nonzero while invalid");

	// The reject counter only ever moves up by one.
	a_rej_step: assert property (@(posedge clk) disable iff (!arst_n)
		rejected_count != $past(rejected_count) |->
			rejected_count == $past(rejected_count) + 32'd1)
		else $error("reject counter jumped");

endmodule

bind range_height_velocity_filter_core rhvf_checker u_rhvf_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .valid_res(valid_res),
	.velocity(velocity), .rejected_count(rejected_count)
);

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Height and velocity filter testbench
// Drives service ticks through the filter core, predicts each result word with a
// cycle-free filter model unless the tick types it in; compares field by field.
// Configuration changes only while the core is idle; idling varies by phase.
// ----------------------------------------------------------------------------
module tb;
	import rhvf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        new_frame = 1'b0;
	logic [15:0] range_cm = '0;
	logic [15:0] signal_strength = '0;
	logic [31:0] frame_time_ms = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        valid_res;
	logic [HEIGHT_W-1:0]     height;
	logic signed [VEL_W-1:0] velocity;
	logic [31:0] last_frame_time_ms, age_ms, rejected_count, weak_count;
	logic [15:0] last_range_cm, last_strength;

	range_height_velocity_filter_core dut (.*);

	always #5 clk = ~clk;

	typedef struct packed {
		logic        ok;
		logic [23:0] hgt;
		logic [20:0] vel;
		logic [31:0] ftime;
		logic [31:0] age;
		logic [31:0] rej;
		logic [31:0] wk;
		logic [15:0] rng;
		logic [15:0] str;
	} filt_word_t;

	typedef struct {
		logic        frame;
		logic [15:0] rng;
		logic [15:0] str;
		logic [31:0] ftime;
		logic [31:0] now;
		logic        fixed;   // the expected word below is typed in
		filt_word_t  want;
	} tick_t;

	// Filter settings and state held by the predictor.
	logic [15:0] p_min_dist, p_max_dist, p_min_str, p_timeout;
	logic [8:0]  p_hgain, p_vgain;
	logic [19:0] p_vlim;
	longint      f_height, f_prior, f_vel;
	logic [31:0] f_acc_time, f_seen_time, f_rej, f_weak;
	logic        f_valid;
	logic [15:0] f_seen_dist, f_seen_str;

	filt_word_t  pending_words[$];
	int          errors = 0;
	int          sender_idle = 0, receiver_stall = 0;
	longint      cycles = 0;
	logic        run_done = 1'b0;

	function automatic longint floor256(longint x);
		if (x >= 0)
			return x >>> 8;
		return -((-x + 255) >>> 8);
	endfunction

	function automatic longint smooth(longint cur, longint target, logic [8:0] gain);
		longint g;
		g = (gain > 256) ? 256 : gain;
		return cur + floor256(g * (target - cur) + 128);
	endfunction

	function automatic filt_word_t filter_tick(tick_t t);
		filt_word_t w;
		logic   dist_ok, str_ok;
		longint raw, rate, lim;
		logic [31:0] dt;
		if (t.frame) begin
			dist_ok = t.rng >= p_min_dist && t.rng <= p_max_dist;
			str_ok = t.str >= p_min_str && t.str != BAD_STRENGTH;
			f_seen_dist = t.rng;
			f_seen_str = t.str;
			f_seen_time = t.ftime;
			if (dist_ok && str_ok) begin
				raw = longint'(t.rng) << FRACTION_BITS;
				if (raw > 64'hFFFFFF)
					raw = 64'hFFFFFF;
				if (f_acc_time == 0) begin
					f_height = raw;
					f_vel = 0;
				end else begin
					dt = t.ftime - f_acc_time;
					f_height = smooth(f_height, raw, p_hgain);
					if (dt >= 2 && dt <= p_timeout) begin
						lim = p_vlim;
						rate = (f_height - f_prior) * 1000 / longint'(dt);
						if (rate < -lim) rate = -lim;
						if (rate > lim) rate = lim;
						f_vel = smooth(f_vel, rate, p_vgain);
					end
				end
				f_prior = f_height;
				f_acc_time = t.ftime;
				f_valid = 1'b1;
			end else begin
				f_rej++;
				if (!str_ok)
					f_weak++;
			end
		end
		if (f_acc_time == 0 || (t.now - f_acc_time) > p_timeout) begin
			f_valid = 1'b0;
			f_vel = 0;
		end
		w.ok = f_valid;
		w.hgt = f_height[23:0];
		w.vel = f_vel[20:0];
		w.ftime = f_seen_time;
		w.age = (f_seen_time != 0) ? t.now - f_seen_time : 32'hFFFFFFFF;
		w.rej = f_rej;
		w.wk = f_weak;
		w.rng = f_seen_dist;
		w.str = f_seen_str;
		return w;
	endfunction

	task automatic report(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $time);
		errors++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_DIST:  p_min_dist = val[15:0];
			REG_MAX_DIST:  p_max_dist = val[15:0];
			REG_MIN_STR:   p_min_str = val[15:0];
			REG_TIMEOUT:   p_timeout = val[15:0];
			REG_H_GAIN:    p_hgain = val[8:0];
			REG_V_GAIN:    p_vgain = val[8:0];
			REG_VEL_LIMIT: p_vlim = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Sends one tick and queues its expected word.
	task automatic send_tick(tick_t t);
		filt_word_t w;
		while ($urandom_range(99) < sender_idle)
			@(posedge clk);
		in_valid <= 1'b1;
		new_frame <= t.frame;
		range_cm <= t.rng;
		signal_strength <= t.str;
		frame_time_ms <= t.ftime;
		now_ms <= t.now;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		w = filter_tick(t);
		if (t.fixed)
			w = t.want;
		pending_words.push_back(w);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		filt_word_t w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					report("unexpected word", 64'd0, 64'd0);
				end else begin
					w = pending_words.pop_front();
					if (valid_res !== w.ok)
						report("valid_res", 64'(valid_res), 64'(w.ok));
					if (height !== w.hgt) report("height", 64'(height), 64'(w.hgt));
					if (velocity !== w.vel)
						report("velocity", 64'($unsigned(velocity)), 64'(w.vel));
					if (last_frame_time_ms !== w.ftime)
						report("last_frame_time_ms", 64'(last_frame_time_ms), 64'(w.ftime));
					if (age_ms !== w.age) report("age_ms", 64'(age_ms), 64'(w.age));
					if (rejected_count !== w.rej)
						report("rejected_count", 64'(rejected_count), 64'(w.rej));
					if (weak_count !== w.wk)
						report("weak_count", 64'(weak_count), 64'(w.wk));
					if (last_range_cm !== w.rng)
						report("last_range_cm", 64'(last_range_cm), 64'(w.rng));
					if (last_strength !== w.str)
						report("last_strength", 64'(last_strength), 64'(w.str));
				end
			end
			out_ready <= ($urandom_range(99) >= receiver_stall);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > 400000 && !run_done) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic tick_t mk(logic f, logic [15:0] d, logic [15:0] s,
			logic [31:0] ft, logic [31:0] nw);
		tick_t t;
		t.frame = f; t.rng = d; t.str = s; t.ftime = ft; t.now = nw;
		t.fixed = 1'b0; t.want = '0;
		return t;
	endfunction

	// Mostly a plausible flight: frames at small time steps with random noise.
	task automatic random_ticks(int n);
		tick_t t;
		logic [31:0] clock_ms;
		int          alt;
		clock_ms = $urandom;
		alt = $urandom_range(1, 1100);
		repeat (n) begin
			clock_ms += $urandom_range(0, 30);
			alt = alt + $urandom_range(0, 40) - 20;
			if (alt < 0) alt = 0;
			t = mk($urandom_range(9) != 0, alt[15:0], 16'($urandom_range(40, 3000)),
				clock_ms, clock_ms + $urandom_range(0, 5));
			case ($urandom_range(19))
				0: t.rng = 16'($urandom);
				1: t.str = 16'($urandom);
				2: t.str = BAD_STRENGTH;
				3: t.now = $urandom;
				4: t.ftime = $urandom_range(1) ? 32'd0 : $urandom;
				5: begin clock_ms += $urandom_range(50, 400); t.ftime = clock_ms; end
				default: ;
			endcase
			send_tick(t);
		end
	endtask

	tick_t plan[$];

	initial begin
		tick_t t;
		p_min_dist = 2; p_max_dist = 1200; p_min_str = 80; p_timeout = 100;
		p_hgain = 90; p_vgain = 51; p_vlim = 128000;
		f_height = 0; f_prior = 0; f_vel = 0; f_acc_time = 0; f_seen_time = 0;
		f_rej = 0; f_weak = 0; f_valid = 0; f_seen_dist = 0; f_seen_str = 0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: after reset, no frame gives all-zero state, age all ones.
		t = mk(1'b0, 16'd0, 16'd0, 32'd0, 32'hFFFFFFFF); t.fixed = 1'b1;
		t.want = '{ok: 1'b0, hgt: 24'd0, vel: 21'd0, ftime: 32'd0, age: 32'hFFFFFFFF,
			rej: 32'd0, wk: 32'd0, rng: 16'd0, str: 16'd0};
		plan.push_back(t);
		t = mk(1'b1, 16'd1201, 16'd500, 32'd10, 32'd10); t.fixed = 1'b1;   // too far
		t.want = '{ok: 1'b0, hgt: 24'd0, vel: 21'd0, ftime: 32'd10, age: 32'd0,
			rej: 32'd1, wk: 32'd0, rng: 16'd1201, str: 16'd500};
		plan.push_back(t);
		// Bad strength marker.
		t = mk(1'b1, 16'd500, BAD_STRENGTH, 32'd12, 32'd15); t.fixed = 1'b1;
		t.want = '{ok: 1'b0, hgt: 24'd0, vel: 21'd0, ftime: 32'd12, age: 32'd3,
			rej: 32'd2, wk: 32'd1, rng: 16'd500, str: BAD_STRENGTH};
		plan.push_back(t);
		t = mk(1'b1, 16'd100, 16'd80, 32'd20, 32'd20); t.fixed = 1'b1;   // seed
		t.want = '{ok: 1'b1, hgt: 24'd25600, vel: 21'd0, ftime: 32'd20, age: 32'd0,
			rej: 32'd2, wk: 32'd1, rng: 16'd100, str: 16'd80};
		plan.push_back(t);
		plan.push_back(mk(1'b1, 16'd120, 16'd900, 32'd30, 32'd31));
		// Extreme climb hits the clamp.
		plan.push_back(mk(1'b1, 16'd1200, 16'd65534, 32'd40, 32'd40));
		// Gap of one: no velocity update.
		plan.push_back(mk(1'b1, 16'd2, 16'd100, 32'd41, 32'd41));
		plan.push_back(mk(1'b1, 16'd1, 16'd100, 32'd45, 32'd45));        // too near
		plan.push_back(mk(1'b1, 16'd300, 16'd79, 32'd50, 32'd50));       // weak
		plan.push_back(mk(1'b1, 16'd300, 16'd200, 32'd141, 32'd141));    // gap at timeout
		plan.push_back(mk(1'b0, 16'd0, 16'd0, 32'd0, 32'd241));          // age at the timeout, still valid
		plan.push_back(mk(1'b1, 16'd300, 16'd200, 32'd0, 32'd250));      // stamped zero
		plan.push_back(mk(1'b1, 16'd400, 16'd200, 32'd260, 32'd260));    // seeds again
		plan.push_back(mk(1'b1, 16'd10, 16'd200, 32'd270, 32'd270));     // fast descent
		plan.push_back(mk(1'b1, 16'd65535, 16'd65535, 32'hFFFFFFFF, 32'hFFFFFFFF));
		plan.push_back(mk(1'b1, 16'd420, 16'd300, 32'hFFFFFFF0, 32'hFFFFFFF0));
		plan.push_back(mk(1'b1, 16'd430, 16'd300, 32'h00000005, 32'h00000008));  // wraps
		plan.push_back(mk(1'b0, 16'd0, 16'd0, 32'hFFFFFFFF, 32'h00000010));
		foreach (plan[i])
			send_tick(plan[i]);
		drain();

		// Default settings first, then extremes and random settings.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin sender_idle = 0; receiver_stall = 0; end
				1: begin sender_idle = 86; receiver_stall = 0; end
				2: begin sender_idle = 0; receiver_stall = 86; end
				default: begin sender_idle = 33; receiver_stall = 33; end
			endcase
			if (ph == 1) begin
				write_reg(REG_MIN_DIST, 20'd0); write_reg(REG_MAX_DIST, 20'hFFFF);
				write_reg(REG_MIN_STR, 20'd0); write_reg(REG_TIMEOUT, 20'hFFFF);
				write_reg(REG_H_GAIN, 20'd256); write_reg(REG_V_GAIN, 20'd256);
				write_reg(REG_VEL_LIMIT, 20'hFFFFF);
			end else if (ph == 2) begin
				write_reg(REG_MIN_DIST, 20'hFFFF); write_reg(REG_MAX_DIST, 20'd0);
				write_reg(REG_MIN_STR, 20'hFFFF); write_reg(REG_TIMEOUT, 20'd2);
				write_reg(REG_H_GAIN, 20'd0); write_reg(REG_V_GAIN, 20'd0);
				write_reg(REG_VEL_LIMIT, 20'd0);
			end else if (ph == 3) begin
				write_reg(REG_MIN_DIST, 20'd2); write_reg(REG_MAX_DIST, 20'd1200);
				write_reg(REG_MIN_STR, 20'd80); write_reg(REG_TIMEOUT, 20'd100);
				write_reg(REG_H_GAIN, 20'h1FF); write_reg(REG_V_GAIN, 20'd300);
				write_reg(REG_VEL_LIMIT, 20'd500);
			end else if (ph > 3) begin
				write_reg(REG_MIN_DIST, 20'($urandom_range(0, 20)));
				write_reg(REG_MAX_DIST, 20'($urandom_range(800, 65535)));
				write_reg(REG_MIN_STR, 20'($urandom_range(0, 200)));
				write_reg(REG_TIMEOUT, 20'($urandom_range(2, 300)));
				write_reg(REG_H_GAIN, 20'($urandom_range(0, 511)));
				write_reg(REG_V_GAIN, 20'($urandom_range(0, 511)));
				write_reg(REG_VEL_LIMIT, 20'($urandom));
			end
			random_ticks(50);
			// The sender holds off until the core has answered everything.
			while (pending_words.size() != 0)
				@(posedge clk);
			random_ticks(50);
			drain();
		end

		run_done = 1'b1;
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
